FILE: design/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int TICK_WIDTH = 16;
  localparam int HOLD_COUNT_WIDTH_DEFAULT = 16;

  localparam logic [TICK_WIDTH-1:0] SHORT_MIN_RESET = 16'd1;
  localparam logic [TICK_WIDTH-1:0] LONG_MIN_RESET = 16'd8;

  // bit positions inside a 3-bit flag group
  localparam int FLAG_SHORT = 0;
  localparam int FLAG_LONG = 1;
  localparam int FLAG_REPEAT = 2;
  localparam int FLAG_WIDTH = 3;

  typedef logic [FLAG_WIDTH-1:0] flags_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_CONSUME = 2'd1,
    OP_FLUSH   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic {
    REG_SHORT_MIN = 1'b0,
    REG_LONG_MIN  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [TICK_WIDTH-1:0] short_min;
    logic [TICK_WIDTH-1:0] long_min;
  } thresh_t;

endpackage

FILE: design/bpc_button.sv
`timescale 1ns / 1ps

module bpc_button #(
  parameter int HOLD_COUNT_WIDTH = bpc_pkg::HOLD_COUNT_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tick,
  input  logic             pressed,
  input  bpc_pkg::thresh_t thresh,
  output bpc_pkg::flags_t  events
);
  import bpc_pkg::*;

  localparam int CMP_WIDTH = (HOLD_COUNT_WIDTH > TICK_WIDTH) ? HOLD_COUNT_WIDTH : TICK_WIDTH;

  logic [HOLD_COUNT_WIDTH-1:0] hold_count;
  logic [HOLD_COUNT_WIDTH-1:0] hold_count_next;
  logic [CMP_WIDTH-1:0] held;
  logic [CMP_WIDTH-1:0] short_min;
  logic [CMP_WIDTH-1:0] long_min;
  logic saturated;

  assign held = CMP_WIDTH'(hold_count);
  assign short_min = CMP_WIDTH'(thresh.short_min);
  assign long_min = CMP_WIDTH'(thresh.long_min);
  assign saturated = &hold_count;

  always_comb begin
    events = '0;
    hold_count_next = hold_count;
    if (tick) begin
      if (pressed) begin
        events[FLAG_LONG] = (held == long_min);
        events[FLAG_REPEAT] = (held > long_min);
        if (!saturated) begin
          hold_count_next = hold_count + HOLD_COUNT_WIDTH'(1);
        end
      end else begin
        events[FLAG_SHORT] = (held >= short_min) && (held <= long_min);
        hold_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count <= '0;
    end else begin
      hold_count <= hold_count_next;
    end
  end

endmodule

FILE: design/button_press_classifier_core.sv
`timescale 1ns / 1ps

// channel   | dir | tdata (lsb up)                                  | tuser
// s_axis    | in  | one_pressed, two_pressed, select, mask[2:0], pad | operation[1:0]
// m_axis    | out | consumed[2:0], one_pending[2:0], two_pending[2:0] | -
// cfg       | in  | cfg_we, cfg_index (0 short_min, 1 long_min), cfg_data[15:0]
//
// one word per cycle: the state update and the result are formed in the
// cycle a word is accepted and land in the output register at that edge
// the output register is the only stage, so a new word is taken whenever
// it is empty or being drained in the same cycle
// a stalled output holds the word and blocks further input
// rst is synchronous: hold counters and pending flags clear, thresholds
// return to 1 and 8

module button_press_classifier_core #(
  parameter int HOLD_COUNT_WIDTH = bpc_pkg::HOLD_COUNT_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // one_pressed, two_pressed, select, event_mask[2:0], zero pad
  input  logic [7:0]                         s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // consumed_events[2:0], one_pending[2:0], two_pending[2:0], zero pad
  output logic [15:0]                        m_axis_tdata,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [bpc_pkg::TICK_WIDTH-1:0]     cfg_data
);
  import bpc_pkg::*;

  // input word fields
  op_t    op;
  logic   one_pressed;
  logic   two_pressed;
  logic   sel;
  flags_t mask;
  logic   accept;
  logic   tick;

  thresh_t thresh;
  flags_t  one_events;
  flags_t  two_events;

  // pending flags per button
  flags_t pend_one;
  flags_t pend_two;
  flags_t pend_one_next;
  flags_t pend_two_next;
  flags_t consumed_next;

  // output register
  flags_t res_consumed;
  flags_t res_one;
  flags_t res_two;

  assign op = op_t'(s_axis_tuser);
  assign one_pressed = s_axis_tdata[0];
  assign two_pressed = s_axis_tdata[1];
  assign sel = s_axis_tdata[2];
  assign mask = s_axis_tdata[5:3];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;

  // a tick with both buttons down leaves everything as it is
  assign tick = accept && (op == OP_TICK) && !(one_pressed && two_pressed);

  // threshold registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh.short_min <= SHORT_MIN_RESET;
      thresh.long_min <= LONG_MIN_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_SHORT_MIN: thresh.short_min <= cfg_data;
        REG_LONG_MIN:  thresh.long_min <= cfg_data;
      endcase
    end
  end

  bpc_button #(
    .HOLD_COUNT_WIDTH(HOLD_COUNT_WIDTH)
  ) u_button_one (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .pressed (one_pressed),
    .thresh  (thresh),
    .events  (one_events)
  );

  bpc_button #(
    .HOLD_COUNT_WIDTH(HOLD_COUNT_WIDTH)
  ) u_button_two (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .pressed (two_pressed),
    .thresh  (thresh),
    .events  (two_events)
  );

  // pending flag update; events from the buttons are zero unless ticking
  always_comb begin
    pend_one_next = pend_one | one_events;
    pend_two_next = pend_two | two_events;
    consumed_next = '0;
    if (accept) begin
      unique case (op)
        OP_CONSUME: begin
          consumed_next = (sel ? pend_two : pend_one) & mask;
          if (sel) begin
            pend_two_next = pend_two & ~consumed_next;
          end else begin
            pend_one_next = pend_one & ~consumed_next;
          end
        end
        OP_FLUSH: begin
          pend_one_next = '0;
          pend_two_next = '0;
        end
        OP_TICK, OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_one <= '0;
      pend_two <= '0;
    end else begin
      pend_one <= pend_one_next;
      pend_two <= pend_two_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res_consumed <= consumed_next;
      res_one <= pend_one_next;
      res_two <= pend_two_next;
    end
  end

  assign m_axis_tdata = {7'd0, res_two, res_one, res_consumed};

`ifndef SYNTHESIS
  // flush leaves both buttons with nothing pending
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_FLUSH) |=> (res_one == '0) && (res_two == '0))
    else $error("flush left pending flags");

  // only a consume word reports consumed flags
  a_consumed_only_on_consume: assert property (@(posedge clk) disable iff (rst)
    accept && (op != OP_CONSUME) |=> res_consumed == '0)
    else $error("consumed flags on a non-consume word");

  // consumed flags stay within the mask and are gone from the pending set
  a_consume_masked: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_CONSUME) |=>
      ((res_consumed & ~$past(mask)) == '0) &&
      ((res_consumed & ($past(sel) ? res_two : res_one)) == '0))
    else $error("consume outside mask or flags not cleared");

  // pending flags in the result match the live state right after a word
  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    accept |=> (res_one == pend_one) && (res_two == pend_two))
    else $error("result pending flags differ from state");
`endif

endmodule

FILE: verif/tb_button_press_classifier_core.sv
`timescale 1ns / 1ps

module tb_button_press_classifier_core;
  import bpc_pkg::*;

  localparam int HOLD_W = 16;
  // cycles with no word moving on either side before the run is abandoned
  localparam int IDLE_LIMIT = 5000;
  // single output register: the settle wait covers anything in flight
  localparam int SETTLE_CYCLES = 3;

  typedef struct packed {
    flags_t consumed;
    flags_t one_pending;
    flags_t two_pending;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [TICK_WIDTH-1:0] cfg_data = '0;

  // predictor state
  logic [HOLD_W-1:0] hold_ticks [2];
  flags_t flags_now [2];
  logic [TICK_WIDTH-1:0] short_min_q;
  logic [TICK_WIDTH-1:0] long_min_q;
  report_t pending_reports [$];

  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // press script for the random traffic
  int active_btn = 0;
  int run_len = 0;
  int run_target = 0;

  button_press_classifier_core #(
    .HOLD_COUNT_WIDTH(HOLD_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (recv_stall_pct == 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog on forward progress
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // one button on one sample tick
  function automatic void sample_button(int b, bit pressed);
    longint unsigned held;
    longint unsigned cmax;
    held = hold_ticks[b];
    cmax = (64'd1 << HOLD_W) - 1;
    if (pressed) begin
      if (held == long_min_q) begin
        flags_now[b][FLAG_LONG] = 1'b1;
      end else if (held > long_min_q) begin
        flags_now[b][FLAG_REPEAT] = 1'b1;
      end
      if (held < cmax) begin
        hold_ticks[b] = hold_ticks[b] + HOLD_W'(1);
      end
    end else begin
      if (held >= short_min_q && held <= long_min_q) begin
        flags_now[b][FLAG_SHORT] = 1'b1;
      end
      hold_ticks[b] = '0;
    end
  endfunction

  // next state and the report an accepted word produces
  function automatic void classify_word(op_t op, bit one_p, bit two_p, bit sel, flags_t mask);
    report_t rep;
    flags_t taken;
    taken = '0;
    case (op)
      OP_TICK: begin
        // both buttons down: tick is ignored
        if (!(one_p && two_p)) begin
          sample_button(0, one_p);
          sample_button(1, two_p);
        end
      end
      OP_CONSUME: begin
        taken = flags_now[sel] & mask;
        flags_now[sel] = flags_now[sel] & ~taken;
      end
      OP_FLUSH: begin
        flags_now[0] = '0;
        flags_now[1] = '0;
      end
      default: ;
    endcase
    rep.consumed = taken;
    rep.one_pending = flags_now[0];
    rep.two_pending = flags_now[1];
    pending_reports.push_back(rep);
  endfunction

  // result checker
  always @(posedge clk) begin
    report_t exp_rep;
    report_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.consumed = m_axis_tdata[2:0];
      got.one_pending = m_axis_tdata[5:3];
      got.two_pending = m_axis_tdata[8:6];
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_rep = pending_reports.pop_front();
        if (got.consumed !== exp_rep.consumed) begin
          $display("%0t consumed_events: expected %0d actual %0d",
                   $time, exp_rep.consumed, got.consumed);
          errors++;
        end
        if (got.one_pending !== exp_rep.one_pending) begin
          $display("%0t button_one_pending: expected %0d actual %0d",
                   $time, exp_rep.one_pending, got.one_pending);
          errors++;
        end
        if (got.two_pending !== exp_rep.two_pending) begin
          $display("%0t button_two_pending: expected %0d actual %0d",
                   $time, exp_rep.two_pending, got.two_pending);
          errors++;
        end
      end
    end
  end

  // drive one word, hold it until taken, then predict
  task automatic send_word(op_t op, bit one_p, bit two_p, bit sel, flags_t mask);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {2'b00, mask, sel, two_p, one_p};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    classify_word(op, one_p, two_p, sel, mask);
  endtask

  // stop sending and wait until every report has come back
  task automatic drain_reports();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [TICK_WIDTH-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SHORT_MIN) begin
      short_min_q = value;
    end else begin
      long_min_q = value;
    end
  endtask

  task automatic set_thresholds(logic [TICK_WIDTH-1:0] short_min, logic [TICK_WIDTH-1:0] long_min);
    drain_reports();
    write_reg(REG_SHORT_MIN, short_min);
    write_reg(REG_LONG_MIN, long_min);
  endtask

  // mostly well-formed presses of one button at a time, some noise
  task automatic press_traffic(int count);
    int r;
    int cap;
    bit one_p;
    bit two_p;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if ($urandom_range(0, 9) == 0) begin
          one_p = 1'($urandom_range(0, 1));
          two_p = 1'($urandom_range(0, 1));
        end else if (run_len < run_target) begin
          one_p = (active_btn == 0);
          two_p = (active_btn == 1);
          run_len++;
        end else begin
          // release, then pick the next press
          one_p = 1'b0;
          two_p = 1'b0;
          cap = (long_min_q > 37) ? 40 : long_min_q + 3;
          active_btn = $urandom_range(0, 1);
          run_target = $urandom_range(0, cap);
          run_len = 0;
        end
        send_word(OP_TICK, one_p, two_p, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      end else if (r < 88) begin
        send_word(OP_CONSUME, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      end else if (r < 94) begin
        send_word(OP_FLUSH, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      end else begin
        send_word(OP_NONE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      end
    end
  endtask

  // reset thresholds: long, repeat, short, consume, flush, unused op
  task automatic test_directed();
    send_word(OP_TICK, 1'b1, 1'b1, 1'b0, 3'd0);
    repeat (10) send_word(OP_TICK, 1'b1, 1'b0, 1'b1, 3'd7);
    send_word(OP_TICK, 1'b0, 1'b1, 1'b0, 3'd0);
    send_word(OP_TICK, 1'b0, 1'b1, 1'b1, 3'd7);
    send_word(OP_TICK, 1'b0, 1'b0, 1'b0, 3'd5);
    send_word(OP_CONSUME, 1'b1, 1'b1, 1'b0, 3'd0);
    send_word(OP_CONSUME, 1'b0, 1'b0, 1'b0, 1'b1 << FLAG_LONG);
    send_word(OP_CONSUME, 1'b1, 1'b0, 1'b1, 3'd7);
    send_word(OP_NONE, 1'b1, 1'b1, 1'b1, 3'd7);
    send_word(OP_FLUSH, 1'b0, 1'b1, 1'b0, 3'd2);
    send_word(OP_CONSUME, 1'b0, 1'b0, 1'b0, 3'd7);
  endtask

  // short above long, both zero, widest window
  task automatic test_threshold_extremes();
    set_thresholds(16'hFFFF, 16'hFFFE);
    press_traffic(30);
    set_thresholds(16'h0000, 16'h0000);
    press_traffic(30);
    set_thresholds(16'h0000, 16'hFFFE);
    press_traffic(30);
  endtask

  // hold well past long: long once, repeat after, no short on release
  task automatic test_long_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_thresholds(16'd2, 16'd40);
    repeat (60) send_word(OP_TICK, 1'b1, 1'b0, 1'($urandom_range(0, 1)),
                          3'($urandom_range(0, 7)));
    send_word(OP_TICK, 1'b0, 1'b0, 1'b0, 3'd0);
    send_word(OP_CONSUME, 1'b0, 1'b0, 1'b0, 3'd7);
    send_word(OP_CONSUME, 1'b0, 1'b0, 1'b1, 3'd7);
  endtask

  task automatic test_random_phases();
    // no idling
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_thresholds(16'($urandom_range(0, 4)), 16'($urandom_range(0, 12)));
    press_traffic(120);
    // sender holds off until the pipe is empty
    drain_reports();
    press_traffic(115);
    // sender idle
    send_idle_pct = 67;
    recv_stall_pct = 0;
    set_thresholds(16'($urandom_range(0, 4)), 16'($urandom_range(2, 12)));
    press_traffic(240);
    // receiver stalling
    send_idle_pct = 0;
    recv_stall_pct = 67;
    set_thresholds(16'($urandom_range(0, 4)), 16'($urandom_range(2, 12)));
    press_traffic(240);
    // both sides idling, default thresholds back
    send_idle_pct = 14;
    recv_stall_pct = 14;
    set_thresholds(SHORT_MIN_RESET, LONG_MIN_RESET);
    press_traffic(240);
  endtask

  initial begin
    hold_ticks[0] = '0;
    hold_ticks[1] = '0;
    flags_now[0] = '0;
    flags_now[1] = '0;
    short_min_q = SHORT_MIN_RESET;
    long_min_q = LONG_MIN_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_threshold_extremes();
    test_long_hold();
    test_random_phases();

    drain_reports();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
